FILE: design/esid_pkg.sv
// Shared definitions for the encoder speed and integral drive block:
// field widths, register reset values, register indexes and the sequencer states.
// Depends on nothing else.
`timescale 1ns / 1ps

package esid_pkg;

	// Fixed field widths
	localparam int unsigned TS_W    = 32;
	localparam int unsigned SPEED_W = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned INTEG_W = 48;
	localparam int unsigned DUTY_W  = 16;
	localparam int unsigned IDX_W   = 2;

	// Parameter defaults
	localparam int unsigned AVERAGE_TAPS_DEFAULT = 5;
	localparam int unsigned TIME_BITS_DEFAULT    = 32;

	// Register reset values
	localparam logic [CFG_W-1:0] SPEED_CONSTANT_RESET = 16'd2932;
	localparam logic [CFG_W-1:0] PWM_RANGE_RESET      = 16'd255;
	localparam logic             POLARITY_RESET       = 1'b0;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] CFG_SPEED_CONSTANT = 2'd0;
	localparam logic [IDX_W-1:0] CFG_PWM_RANGE      = 2'd1;
	localparam logic [IDX_W-1:0] CFG_POLARITY       = 2'd2;

	// Operation codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Speed saturation limits
	localparam logic [SPEED_W-1:0] SPEED_POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [SPEED_W-1:0] SPEED_NEG_LIMIT = 32'h8000_0000;

	// Integrator limits
	localparam logic [INTEG_W-1:0] INTEG_POS_LIMIT = 48'h7FFF_FFFF_FFFF;
	localparam logic [INTEG_W-1:0] INTEG_NEG_LIMIT = 48'h8000_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPD_DIV,
		ST_SPD_FIX,
		ST_PUSH,
		ST_AVG_LOAD,
		ST_AVG_DIV,
		ST_AVG_FIX,
		ST_INTEG,
		ST_DRIVE,
		ST_DONE
	} esid_state_t;

endpackage

FILE: design/encoder_speed_integral_drive.sv
// Top level of the encoder speed and integral drive block for one wheel.
// Holds the sequencer, the shared bit-serial divider and all block state.
// Depends on esid_pkg.
`timescale 1ns / 1ps

// One wheel channel. An encoder edge item (operation 0) adds its direction to
// the position count and measures speed as direction * speed_constant * 65536
// divided by the microsecond interval since the previous edge (low TIME_BITS of
// the timestamp, modulo 2^TIME_BITS), saturated to signed 32 bits; a zero
// interval gives full-scale speed of the edge's sign and a zero direction gives
// zero speed. The speed enters an AVERAGE_TAPS deep history whose running sum is
// divided by AVERAGE_TAPS, truncated toward zero, to give average_speed. A
// control tick item (operation 1) adds setpoint - average_speed to a 48-bit
// Q32.16 integrator that saturates, and then sets the drive outputs from the
// integrator's integer part clamped to pwm_range: polarity 0 puts positive drive
// on drive_b, polarity 1 on drive_a, negative drive goes to the other pin and
// the unselected pin reads 0. An integrator of exactly zero leaves both drives as
// they were. Every item returns one result with both drives, the average and the
// position. Both divisions run on one restoring divider that produces one
// quotient bit per cycle over DIV_W = 32 + clog2(AVERAGE_TAPS) bits (35 at the
// defaults). An edge item runs the speed division, then pushes the speed into
// the history and runs the average division; the speed division is skipped
// when the interval or direction is zero. A tick item needs no division.
// Items are taken one at a time: item_stall stays high while an item is in work.
// The result sits in an output register, so the next item is accepted while the
// previous result still waits on result_stall. Configuration writes take effect
// at once and are meant to be made while the block is idle.
module encoder_speed_integral_drive #(
	parameter int unsigned AVERAGE_TAPS = esid_pkg::AVERAGE_TAPS_DEFAULT,
	parameter int unsigned TIME_BITS    = esid_pkg::TIME_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                cfg_wr_en,
	input  logic [esid_pkg::IDX_W-1:0]          cfg_index,
	input  logic [esid_pkg::CFG_W-1:0]          cfg_data,
	// input items
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                operation,
	input  logic signed [1:0]                   direction,
	input  logic [esid_pkg::TS_W-1:0]           timestamp,
	input  logic signed [esid_pkg::SPEED_W-1:0] setpoint,
	// result items
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [esid_pkg::DUTY_W-1:0]         drive_a,
	output logic [esid_pkg::DUTY_W-1:0]         drive_b,
	output logic signed [esid_pkg::SPEED_W-1:0] average_speed,
	output logic signed [esid_pkg::SPEED_W-1:0] position
);
	import esid_pkg::*;

	// Width of the history sum; the divider's dividend is as wide.
	localparam int unsigned SUM_W = SPEED_W + $clog2(AVERAGE_TAPS);
	localparam int unsigned DIV_W = SUM_W;
	localparam int unsigned CNT_W = $clog2(DIV_W + 1);
	localparam int unsigned ERR_W = SPEED_W + 1;
	localparam int unsigned ACC_W = INTEG_W + 1;

	// Configuration registers
	logic [CFG_W-1:0] speed_constant_q;
	logic [CFG_W-1:0] pwm_range_q;
	logic             polarity_q;

	// Block state
	esid_state_t                 state_q, state_d;
	logic [CNT_W-1:0]            cnt_q;
	logic [SPEED_W-1:0]          edge_count_q;
	logic [TIME_BITS-1:0]        last_time_q;
	logic signed [SPEED_W-1:0]   hist_q [AVERAGE_TAPS];
	logic signed [SUM_W-1:0]     sum_q;
	logic signed [SPEED_W-1:0]   avg_q;
	logic signed [INTEG_W-1:0]   integ_q;
	logic [DUTY_W-1:0]           held_a_q;
	logic [DUTY_W-1:0]           held_b_q;
	logic                        result_valid_q;

	// Working registers of the item in flight
	logic [DIV_W-1:0]            div_n_q;
	logic [TIME_BITS-1:0]        div_r_q;
	logic [TIME_BITS-1:0]        div_d_q;
	logic                        neg_q;
	logic signed [SPEED_W-1:0]   spd_q;
	logic signed [ERR_W-1:0]     err_q;
	logic [DUTY_W-1:0]           drive_a_q;
	logic [DUTY_W-1:0]           drive_b_q;
	logic signed [SPEED_W-1:0]   average_q;
	logic signed [SPEED_W-1:0]   position_q;

	// Sequencer outputs
	logic accept;
	logic div_step;
	logic result_load;
	logic div_last;

	// Edge item decode
	logic [TIME_BITS-1:0] ts_low;
	logic [TIME_BITS-1:0] interval;
	logic [CFG_W:0]       scaled_const;

	// Divider step
	logic [TIME_BITS:0]   rem_shift;
	logic [TIME_BITS:0]   rem_diff;
	logic                 rem_ge;

	// Speed and average finishing
	logic                 quo_big;
	logic [SUM_W-1:0]     sum_mag;

	// Integrator and drive
	logic signed [ACC_W-1:0]   acc_sum;
	logic signed [INTEG_W-1:0] acc_sat;
	logic [INTEG_W-1:0]        integ_mag;
	logic [SPEED_W-1:0]        whole_mag;
	logic [DUTY_W-1:0]         duty;
	logic                      on_a;

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	assign div_last = (cnt_q == CNT_W'(1));

	always_comb begin
		item_stall  = (state_q != ST_IDLE);
		div_step    = (state_q == ST_SPD_DIV) || (state_q == ST_AVG_DIV);
		result_load = (state_q == ST_DONE) && (!result_valid_q || !result_stall);
		accept      = item_valid && (state_q == ST_IDLE);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_TICK) begin
						state_d = ST_INTEG;
					end else if (direction == 2'sd0 || interval == '0) begin
						state_d = ST_PUSH;
					end else begin
						state_d = ST_SPD_DIV;
					end
				end
			end
			ST_SPD_DIV: begin
				if (div_last) begin
					state_d = ST_SPD_FIX;
				end
			end
			ST_SPD_FIX:  state_d = ST_PUSH;
			ST_PUSH:     state_d = ST_AVG_LOAD;
			ST_AVG_LOAD: state_d = ST_AVG_DIV;
			ST_AVG_DIV: begin
				if (div_last) begin
					state_d = ST_AVG_FIX;
				end
			end
			ST_AVG_FIX:  state_d = ST_DONE;
			ST_INTEG:    state_d = ST_DRIVE;
			ST_DRIVE:    state_d = ST_DONE;
			ST_DONE: begin
				if (result_load) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Datapath logic
	// ---------------------------------------------------------------------
	assign ts_low   = timestamp[TIME_BITS-1:0];
	assign interval = ts_low - last_time_q;
	// |direction| is 1 or 2 on the division path, so the product is a shift.
	assign scaled_const = (direction == -2'sd2) ? {speed_constant_q, 1'b0}
	                                            : {1'b0, speed_constant_q};

	// One restoring step: bring down the next dividend bit, subtract if it fits.
	assign rem_shift = {div_r_q, div_n_q[DIV_W-1]};
	assign rem_diff  = rem_shift - {1'b0, div_d_q};
	assign rem_ge    = (rem_shift >= {1'b0, div_d_q});

	// A quotient of 2^31 or more saturates in either sign.
	assign quo_big = |div_n_q[DIV_W-1:SPEED_W-1];
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	assign acc_sum = ACC_W'(integ_q) + ACC_W'(err_q);
	always_comb begin
		if (acc_sum[ACC_W-1] != acc_sum[ACC_W-2]) begin
			acc_sat = acc_sum[ACC_W-1] ? INTEG_NEG_LIMIT : INTEG_POS_LIMIT;
		end else begin
			acc_sat = acc_sum[INTEG_W-1:0];
		end
	end

	// Truncation toward zero of the integer part is the magnitude shifted down.
	assign integ_mag = integ_q[INTEG_W-1] ? INTEG_W'(-integ_q) : INTEG_W'(integ_q);
	assign whole_mag = integ_mag[INTEG_W-1:INTEG_W-SPEED_W];
	assign duty      = (whole_mag > SPEED_W'(pwm_range_q)) ? pwm_range_q
	                                                       : whole_mag[DUTY_W-1:0];
	assign on_a      = integ_q[INTEG_W-1] ? !polarity_q : polarity_q;

	// ---------------------------------------------------------------------
	// Control and state registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_constant_q <= SPEED_CONSTANT_RESET;
			pwm_range_q      <= PWM_RANGE_RESET;
			polarity_q       <= POLARITY_RESET;
			state_q          <= ST_IDLE;
			cnt_q            <= '0;
			edge_count_q     <= '0;
			last_time_q      <= '0;
			for (int i = 0; i < AVERAGE_TAPS; i++) begin
				hist_q[i] <= '0;
			end
			sum_q            <= '0;
			avg_q            <= '0;
			integ_q          <= '0;
			held_a_q         <= '0;
			held_b_q         <= '0;
			result_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_SPEED_CONSTANT: speed_constant_q <= cfg_data;
					CFG_PWM_RANGE:      pwm_range_q      <= cfg_data;
					CFG_POLARITY:       polarity_q       <= cfg_data[0];
					default:            ;
				endcase
			end

			if (accept && operation == OP_EDGE) begin
				edge_count_q <= edge_count_q + SPEED_W'(direction);
				last_time_q  <= ts_low;
				cnt_q        <= CNT_W'(DIV_W);
			end else if (state_q == ST_AVG_LOAD) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end

			if (state_q == ST_PUSH) begin
				for (int i = AVERAGE_TAPS - 1; i > 0; i--) begin
					hist_q[i] <= hist_q[i-1];
				end
				hist_q[0] <= spd_q;
				sum_q     <= sum_q + SUM_W'(spd_q) - SUM_W'(hist_q[AVERAGE_TAPS-1]);
			end

			if (state_q == ST_AVG_FIX) begin
				avg_q <= neg_q ? SPEED_W'(-div_n_q[SPEED_W-1:0])
				               : SPEED_W'(div_n_q[SPEED_W-1:0]);
			end

			if (state_q == ST_INTEG) begin
				integ_q <= acc_sat;
			end

			if (state_q == ST_DRIVE && integ_q != '0) begin
				held_a_q <= on_a ? duty : '0;
				held_b_q <= on_a ? '0 : duty;
			end

			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Working and result payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= direction[1];
			// Target speed minus average, one bit wider so it cannot wrap.
			err_q   <= ERR_W'(setpoint) - ERR_W'(avg_q);
			div_n_q <= DIV_W'({scaled_const, 16'h0000});
			div_r_q <= '0;
			div_d_q <= interval;
			if (direction == 2'sd0) begin
				spd_q <= '0;
			end else begin
				spd_q <= direction[1] ? SPEED_NEG_LIMIT : SPEED_POS_LIMIT;
			end
		end else if (div_step) begin
			div_r_q <= rem_ge ? rem_diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
			div_n_q <= {div_n_q[DIV_W-2:0], rem_ge};
		end else if (state_q == ST_SPD_FIX) begin
			if (quo_big) begin
				spd_q <= neg_q ? SPEED_NEG_LIMIT : SPEED_POS_LIMIT;
			end else begin
				spd_q <= neg_q ? SPEED_W'(-div_n_q[SPEED_W-1:0])
				               : SPEED_W'(div_n_q[SPEED_W-1:0]);
			end
		end else if (state_q == ST_AVG_LOAD) begin
			neg_q   <= sum_q[SUM_W-1];
			div_n_q <= sum_mag;
			div_r_q <= '0;
			div_d_q <= TIME_BITS'(AVERAGE_TAPS);
		end

		if (result_load) begin
			drive_a_q  <= held_a_q;
			drive_b_q  <= held_b_q;
			average_q  <= avg_q;
			position_q <= edge_count_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign drive_a       = drive_a_q;
	assign drive_b       = drive_b_q;
	assign average_speed = average_q;
	assign position      = position_q;

endmodule

FILE: tb/esid_drive_checker.sv
// Result checker for the encoder speed and integral drive block.
// Watches the register port and both item channels, predicts each result and compares it.
// Depends on esid_pkg.
`timescale 1ns / 1ps

module esid_drive_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [esid_pkg::IDX_W-1:0]          cfg_index,
	input  logic [esid_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                item_valid,
	input  logic                                item_stall,
	input  logic                                operation,
	input  logic signed [1:0]                   direction,
	input  logic [esid_pkg::TS_W-1:0]           timestamp,
	input  logic signed [esid_pkg::SPEED_W-1:0] setpoint,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic [esid_pkg::DUTY_W-1:0]         drive_a,
	input  logic [esid_pkg::DUTY_W-1:0]         drive_b,
	input  logic signed [esid_pkg::SPEED_W-1:0] average_speed,
	input  logic signed [esid_pkg::SPEED_W-1:0] position,
	output int                                  errors,
	output int                                  pending,
	output int                                  checked
);

	import esid_pkg::*;

	localparam int     TAPS       = AVERAGE_TAPS_DEFAULT;
	localparam longint INTEG_HI   = $signed(INTEG_POS_LIMIT);
	localparam longint INTEG_LO   = $signed(INTEG_NEG_LIMIT);
	localparam longint SPEED_HI   = 64'sd2147483647;
	localparam longint SPEED_LO   = -64'sd2147483648;

	typedef struct packed {
		logic [DUTY_W-1:0]         duty_a;
		logic [DUTY_W-1:0]         duty_b;
		logic signed [SPEED_W-1:0] mean_speed;
		logic signed [SPEED_W-1:0] edge_pos;
	} drive_result_t;

	// Register copies and block state as the predictor sees them.
	logic [CFG_W-1:0]          scale_k;
	logic [CFG_W-1:0]          duty_cap;
	logic                      drive_flip;
	logic [SPEED_W-1:0]        edge_total;
	logic [TS_W-1:0]           prev_edge_ts;
	logic signed [SPEED_W-1:0] speed_hist [TAPS];
	logic signed [INTEG_W-1:0] integ_acc;
	logic [DUTY_W-1:0]         hold_a;
	logic [DUTY_W-1:0]         hold_b;

	drive_result_t expected_q [$];
	drive_result_t want;
	int            dir_i;
	int            k;
	longint        acc_w;
	longint        whole_w;

	// Speed of one edge in Q16.16. The timestamp is a full 32 bits wide, so the
	// interval needs no further masking.
	function automatic logic signed [SPEED_W-1:0] edge_speed_q16(input int dir,
			input logic [TS_W-1:0] gap);
		longint quo;
		if (dir == 0)
			return '0;
		if (gap == 0)
			return (dir > 0) ? SPEED_POS_LIMIT : SPEED_NEG_LIMIT;
		quo = (longint'(dir < 0 ? -dir : dir) * longint'(scale_k) * 65536) / longint'(gap);
		if (dir < 0)
			quo = -quo;
		if (quo > SPEED_HI)
			return SPEED_POS_LIMIT;
		if (quo < SPEED_LO)
			return SPEED_NEG_LIMIT;
		return quo[SPEED_W-1:0];
	endfunction

	// Moving average of the speed history, truncated toward zero.
	function automatic logic signed [SPEED_W-1:0] history_mean();
		longint sum;
		sum = 0;
		for (int i = 0; i < TAPS; i++)
			sum += speed_hist[i];
		return SPEED_W'(sum / TAPS);
	endfunction

	task automatic check_field(input string what, input logic signed [31:0] exp_v,
			input logic signed [31:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t ns: %s expected %0d, got %0d", $time, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_k      = SPEED_CONSTANT_RESET;
			duty_cap     = PWM_RANGE_RESET;
			drive_flip   = POLARITY_RESET;
			edge_total   = '0;
			prev_edge_ts = '0;
			for (k = 0; k < TAPS; k++)
				speed_hist[k] = '0;
			integ_acc    = '0;
			hold_a       = '0;
			hold_b       = '0;
			expected_q.delete();
			errors       = 0;
			checked      = 0;
			pending     <= 0;
		end else begin
			// Results first: one taken at this edge belongs to an earlier item.
			if (result_valid && !result_stall) begin
				checked++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t ns: expected no result, got drive_a %0d drive_b %0d",
						$time, drive_a, drive_b);
				end else begin
					want = expected_q.pop_front();
					check_field("drive_a", 32'(want.duty_a), 32'(drive_a));
					check_field("drive_b", 32'(want.duty_b), 32'(drive_b));
					check_field("average_speed", want.mean_speed, average_speed);
					check_field("position", want.edge_pos, position);
				end
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_SPEED_CONSTANT: scale_k    = cfg_data;
					CFG_PWM_RANGE:      duty_cap   = cfg_data;
					CFG_POLARITY:       drive_flip = cfg_data[0];
					default: ;
				endcase
			end

			if (item_valid && !item_stall) begin
				if (operation == OP_EDGE) begin
					dir_i = int'(direction);
					edge_total = edge_total + dir_i;
					for (k = TAPS - 1; k > 0; k--)
						speed_hist[k] = speed_hist[k-1];
					speed_hist[0] = edge_speed_q16(dir_i, timestamp - prev_edge_ts);
					prev_edge_ts = timestamp;
				end else begin
					acc_w = longint'(integ_acc) + longint'(setpoint)
						- longint'(history_mean());
					if (acc_w > INTEG_HI)
						acc_w = INTEG_HI;
					if (acc_w < INTEG_LO)
						acc_w = INTEG_LO;
					integ_acc = acc_w[INTEG_W-1:0];
					// An integrator of exactly zero leaves the held drives alone.
					if (acc_w != 0) begin
						whole_w = acc_w / 65536;
						if (whole_w < 0)
							whole_w = -whole_w;
						if (whole_w > longint'(duty_cap))
							whole_w = longint'(duty_cap);
						if ((acc_w > 0) ? drive_flip : !drive_flip) begin
							hold_a = whole_w[DUTY_W-1:0];
							hold_b = '0;
						end else begin
							hold_a = '0;
							hold_b = whole_w[DUTY_W-1:0];
						end
					end
				end
				want.duty_a     = hold_a;
				want.duty_b     = hold_b;
				want.mean_speed = history_mean();
				want.edge_pos   = edge_total;
				expected_q.push_back(want);
			end

			pending <= expected_q.size();
		end
	end

endmodule

FILE: tb/encoder_speed_integral_drive_test.sv
// Top of the testbench for the encoder speed and integral drive block.
// Drives items and register writes, stalls results, and reports the verdict.
// Depends on esid_pkg, encoder_speed_integral_drive and esid_drive_checker.
`timescale 1ns / 1ps

module encoder_speed_integral_drive_test;

	import esid_pkg::*;

	// Direction codes as the 2-bit signed field carries them.
	localparam logic signed [1:0] DIR_FWD  = 2'sb01;
	localparam logic signed [1:0] DIR_REV  = 2'sb11;
	localparam logic signed [1:0] DIR_NONE = 2'sb00;
	localparam logic signed [1:0] DIR_REV2 = 2'sb10;

	localparam int TAPS = AVERAGE_TAPS_DEFAULT;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_wr_en    = 1'b0;
	logic [IDX_W-1:0]          cfg_index    = '0;
	logic [CFG_W-1:0]          cfg_data     = '0;
	logic                      item_valid   = 1'b0;
	logic                      item_stall;
	logic                      operation    = OP_EDGE;
	logic signed [1:0]         direction    = DIR_NONE;
	logic [TS_W-1:0]           timestamp    = '0;
	logic signed [SPEED_W-1:0] setpoint     = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic [DUTY_W-1:0]         drive_a;
	logic [DUTY_W-1:0]         drive_b;
	logic signed [SPEED_W-1:0] average_speed;
	logic signed [SPEED_W-1:0] position;

	int errors;
	int pending;
	int checked;

	// Stimulus bookkeeping. last_ts only steers the choice of edge intervals.
	bit            quiet    = 1'b0;
	logic [TS_W-1:0] last_ts = '0;
	int            sent     = 0;
	int            n_edges  = 0;
	int            n_ticks  = 0;
	int            settings = 1;
	int            goal;
	int            phase;

	encoder_speed_integral_drive dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.direction     (direction),
		.timestamp     (timestamp),
		.setpoint      (setpoint),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.drive_a       (drive_a),
		.drive_b       (drive_b),
		.average_speed (average_speed),
		.position      (position)
	);

	esid_drive_checker drive_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.direction     (direction),
		.timestamp     (timestamp),
		.setpoint      (setpoint),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.drive_a       (drive_a),
		.drive_b       (drive_b),
		.average_speed (average_speed),
		.position      (position),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random with a chance of 27 in a hundred, except during
	// the closing run, which goes at full speed on both sides.
	always @(posedge clk) begin
		result_stall <= !quiet && ($urandom_range(99) < 27);
	end

	// Presents one item and holds it until the block takes it. The task returns
	// at the accepting edge, so a following call can keep valid high without a
	// dip. About one item in four is preceded by an idle gap, mostly short but
	// now and then long enough to land anywhere inside an edge computation.
	task automatic send_item(input logic op, input logic signed [1:0] dir,
			input logic [TS_W-1:0] ts, input logic signed [SPEED_W-1:0] sp);
		int gap;
		if (!quiet && $urandom_range(99) < 27) begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation  <= op;
		direction  <= dir;
		timestamp  <= ts;
		setpoint   <= sp;
		do @(posedge clk); while (item_stall);
		sent++;
		if (op == OP_EDGE) begin
			n_edges++;
			last_ts = ts;
		end else begin
			n_ticks++;
		end
	endtask

	// Every item yields exactly one result, and the result only appears once the
	// work on its item is done, so an empty expectation store means an idle block.
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all three registers on consecutive cycles once the block is idle.
	task automatic set_config(input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] cap,
			input logic flip);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_SPEED_CONSTANT;
		cfg_data  <= scale;
		@(posedge clk);
		cfg_index <= CFG_PWM_RANGE;
		cfg_data  <= cap;
		@(posedge clk);
		cfg_index <= CFG_POLARITY;
		cfg_data  <= {{(CFG_W-1){1'b0}}, flip};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	// One stretch of plausible wheel activity: a run of edges in one direction
	// with intervals from zero up to the full 32-bit range, then a few control
	// ticks. A share of the calls instead sends a single item with every field
	// random, so that broken sequences and odd field values also occur.
	task automatic random_burst();
		logic signed [1:0]         dir;
		logic [TS_W-1:0]           gap;
		logic signed [SPEED_W-1:0] sp;
		int                        run_len;
		if ($urandom_range(99) < 15) begin
			send_item(1'($urandom_range(1)), 2'($urandom_range(3)), $urandom, $urandom);
		end else begin
			dir = $urandom_range(1) ? DIR_FWD : DIR_REV;
			if ($urandom_range(9) == 0)
				dir = $urandom_range(1) ? DIR_NONE : DIR_REV2;
			run_len = $urandom_range(1, 8);
			repeat (run_len) begin
				case ($urandom_range(9))
					0: gap = '0;
					1: gap = $urandom_range(1, 16);
					2: gap = $urandom;
					default: gap = $urandom_range(50, 20000);
				endcase
				send_item(OP_EDGE, dir, last_ts + gap, $urandom);
			end
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(7))
					0: sp = $urandom;
					1: sp = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
					2: sp = '0;
					default: sp = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
				endcase
				send_item(OP_TICK, 2'($urandom_range(3)), $urandom, sp);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ticks first, while the speed history is still all zero: the average is
		// then zero and the integrator moves by exactly the setpoint. This walks
		// through a drive on pin b, an integrator that returns to exactly zero and
		// keeps the held drive, a small nonzero integrator that clears both pins,
		// a negative drive on pin a, truncation toward zero of a slightly negative
		// integrator, and clamping to the duty limit.
		send_item(OP_TICK, DIR_NONE, '0, 32'sh0003_0000);
		send_item(OP_TICK, DIR_NONE, '0, -32'sh0003_0000);
		send_item(OP_TICK, DIR_NONE, '0, 32'sh0000_0064);
		send_item(OP_TICK, DIR_NONE, '0, -32'sh0002_0064);
		send_item(OP_TICK, DIR_NONE, '0, 32'sh0001_FFFF);
		send_item(OP_TICK, DIR_NONE, '0, 32'sh7FFF_FFFF);
		send_item(OP_TICK, DIR_NONE, '0, 32'sh8000_0000);

		// Edges: zero interval in both directions, a zero direction, the double
		// reverse step, the shortest interval, a long one, a wrap of the
		// timestamp counter, and the longest interval there is.
		send_item(OP_EDGE, DIR_FWD, 32'h0000_0000, '0);
		send_item(OP_EDGE, DIR_REV, 32'h0000_0000, '0);
		send_item(OP_EDGE, DIR_NONE, 32'h0000_0064, '0);
		send_item(OP_EDGE, DIR_REV2, 32'h0000_044C, '0);
		send_item(OP_EDGE, DIR_FWD, 32'h0000_044D, '0);
		send_item(OP_EDGE, DIR_FWD, 32'hFFFF_FFF0, '0);
		send_item(OP_EDGE, DIR_REV, 32'h0000_0010, '0);
		send_item(OP_EDGE, DIR_FWD, 32'h0000_000F, '0);
		send_item(OP_TICK, DIR_NONE, '0, '0);

		// Largest scale: a one-microsecond interval overflows the signed speed
		// range, and the double reverse step overflows even the unsigned quotient.
		set_config(16'hFFFF, 16'hFFFF, 1'b1);
		send_item(OP_EDGE, DIR_FWD, 32'h0000_0010, '0);
		send_item(OP_EDGE, DIR_REV2, 32'h0000_0011, '0);
		send_item(OP_EDGE, DIR_REV2, 32'h0000_0011, '0);
		send_item(OP_TICK, DIR_NONE, '0, 32'sh7FFF_FFFF);
		send_item(OP_TICK, DIR_NONE, '0, 32'sh8000_0000);

		// Random traffic under several register settings, both extremes included.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: ;
				1: set_config(16'd1, 16'd1, 1'b0);
				2: set_config(SPEED_CONSTANT_RESET, PWM_RANGE_RESET, 1'b1);
				default: set_config(CFG_W'($urandom_range(1, 65535)),
					CFG_W'($urandom_range(1, 65535)), 1'($urandom_range(1)));
			endcase
			goal = sent + 190;
			while (sent < goal)
				random_burst();
		end

		// Closing run with no idling on either side. Five zero-interval reverse
		// edges pin the average at the negative speed limit, so each tick with
		// the largest setpoint adds almost 2^32 to the integrator and the drive
		// sits at the duty limit. Then the mirror image pulls it the other way.
		set_config(SPEED_CONSTANT_RESET, 16'hFFFF, 1'b0);
		quiet = 1'b1;
		repeat (TAPS) send_item(OP_EDGE, DIR_REV, last_ts, '0);
		repeat (40) send_item(OP_TICK, DIR_NONE, '0, 32'sh7FFF_FFFF);
		repeat (TAPS) send_item(OP_EDGE, DIR_FWD, last_ts, '0);
		repeat (80) send_item(OP_TICK, DIR_NONE, '0, 32'sh8000_0000);
		quiet = 1'b0;

		wait_idle();
		// Leave room after the longest edge computation for a stray result.
		repeat (100) @(posedge clk);

		$display("Run covered %0d encoder edges and %0d control ticks over %0d register settings.",
			n_edges, n_ticks, settings);
		$display("%0d results compared, ending with a stretch of back-to-back items.", checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: ends a run that hangs.
	initial begin
		#40_000_000;
		$display("Timeout: %0d results still outstanding.", pending);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
design/esid_pkg.sv
design/encoder_speed_integral_drive.sv
tb/esid_drive_checker.sv
tb/encoder_speed_integral_drive_test.sv
